@@ hdl/gap_pkg.sv @@
`timescale 1ns / 1ps

package gap_pkg;

    localparam int POS_W     = 16;
    localparam int EXT_W     = 13;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;
    localparam int PROBE_W   = 12;
    localparam int LEN_W     = 12;
    localparam int COST_W    = 20;
    localparam logic [COST_W-1:0] COST_MAX = '1;
    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

    localparam logic [1:0] CMD_FIND  = 2'd0;
    localparam logic [1:0] CMD_PROBE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd3;

    localparam logic [1:0] DIR_PX = 2'd0;
    localparam logic [1:0] DIR_PY = 2'd1;
    localparam logic [1:0] DIR_NX = 2'd2;
    localparam logic [1:0] DIR_NY = 2'd3;

    typedef struct packed {
        logic open;
        logic closed;
    } flag_t;

    typedef struct packed {
        logic              corridor;
        logic [1:0]        parent;
        logic [COST_W-1:0] est;
        logic [COST_W-1:0] cost;
    } cell_word_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

@@ hdl/gap_ram.sv @@
`timescale 1ns / 1ps

module gap_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/gap_div.sv @@
`timescale 1ns / 1ps

module gap_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [gap_pkg::POS_W-1:0]  dividend,
    input  logic [gap_pkg::EXT_W-1:0]  divisor,
    output logic                       busy,
    output logic [gap_pkg::POS_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(gap_pkg::POS_W + 1);

    logic [gap_pkg::EXT_W:0]   rem_reg, rem_next, rem_sh;
    logic [gap_pkg::POS_W-1:0] q_reg, q_next;
    logic [gap_pkg::EXT_W-1:0] dv_reg, dv_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg[gap_pkg::EXT_W-1:0], q_reg[gap_pkg::POS_W-1]};
        if (start) begin
            rem_next  = '0;
            q_next    = dividend;
            dv_next   = divisor;
            cnt_next  = CNT_W'(gap_pkg::POS_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dv_reg}) begin
                rem_next = rem_sh - {1'b0, dv_reg};
                q_next   = {q_reg[gap_pkg::POS_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                q_next   = {q_reg[gap_pkg::POS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dv_reg  <= dv_next;
        cnt_reg <= cnt_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

@@ hdl/gap_sqrt.sv @@
`timescale 1ns / 1ps

module gap_sqrt #(
    parameter int RAD_W = 22
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 busy,
    output logic [RAD_W/2-1:0]   root
);

    logic [RAD_W-1:0] v_reg, v_next, r_reg, r_next, b_reg, b_next, t;
    logic             busy_reg, busy_next;

    // one result bit per cycle, starting from the top even bit
    always_comb begin
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        t         = r_reg + b_reg;
        if (start) begin
            v_next    = radicand;
            r_next    = '0;
            b_next    = RAD_W'(1) << (RAD_W - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= t) begin
                v_next = v_reg - t;
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            if (b_reg[0]) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign busy = busy_reg;
    assign root = r_reg[RAD_W/2-1:0];

endmodule

@@ hdl/grid_astar_path_finder.sv @@
`timescale 1ns / 1ps
// A* path finder on a 4-connected grid, unit step cost, Euclidean heuristic.
// Input channel s_*: one beat per command. cmd find maps the world positions
// to cells and searches; cmd probe reads one corridor mark; cmd clear wipes
// all marks. Output channel m_*: exactly one result beat per command.
// Configuration (cfg_wr_en/cfg_addr/cfg_wr_data) is to be written by the user
// only while idle; the block itself does not enforce this. The open-set scan,
// which streams every used cell through the flag and cell memories once per
// expansion, dominates the run time of a find. A probe reads its cell through
// S_PRD and S_PWAIT; a clear sweeps every cell of the corridor memory.
// One command is in flight at a time; s_ready is high only between commands.
// After reset the corridor memory is cleared before the first beat is taken.
// A finished result sits in the output register while the next command is taken;
// a stalled receiver holds the block at the end of that command.
module grid_astar_path_finder #(
    parameter int MAX_COLS       = 64,
    parameter int MAX_ROWS       = 64,
    parameter int COST_FRAC_BITS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gap_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [gap_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic [gap_pkg::POS_W-1:0]       s_start_x,
    input  logic [gap_pkg::POS_W-1:0]       s_start_y,
    input  logic [gap_pkg::POS_W-1:0]       s_end_x,
    input  logic [gap_pkg::POS_W-1:0]       s_end_y,
    input  logic [gap_pkg::PROBE_W-1:0]     s_probe_cell,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_path_found,
    output logic [gap_pkg::LEN_W-1:0]       m_path_length,
    output logic                            m_corridor_bit
);

    localparam int NCELLS  = MAX_COLS * MAX_ROWS;
    localparam int IW      = $clog2(NCELLS);
    localparam int UW      = $clog2(NCELLS + 1);
    localparam int CIW     = $clog2(MAX_COLS);
    localparam int RIW     = $clog2(MAX_ROWS);
    localparam int NCW     = $clog2(MAX_COLS + 1);
    localparam int NRW     = $clog2(MAX_ROWS + 1);
    localparam int DW      = (CIW > RIW) ? CIW : RIW;
    localparam int RAD_RAW = 2 * DW + 1 + 2 * COST_FRAC_BITS;
    localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam logic [gap_pkg::COST_W-1:0] STEP = gap_pkg::COST_W'(1 << COST_FRAC_BITS);

    typedef enum logic [21:0] {
        S_CCLR  = 22'h000001,
        S_IDLE  = 22'h000002,
        S_DIV   = 22'h000004,
        S_DIVW  = 22'h000008,
        S_IDX   = 22'h000010,
        S_FCLR  = 22'h000020,
        S_SRD   = 22'h000040,
        S_SWAIT = 22'h000080,
        S_SCAN  = 22'h000100,
        S_SEL   = 22'h000200,
        S_NSET  = 22'h000400,
        S_NADDR = 22'h000800,
        S_NRD   = 22'h001000,
        S_NWAIT = 22'h002000,
        S_CLOSE = 22'h004000,
        S_TCHK  = 22'h008000,
        S_TRD   = 22'h010000,
        S_TWR   = 22'h020000,
        S_TIDX  = 22'h040000,
        S_PRD   = 22'h080000,
        S_PWAIT = 22'h100000,
        S_DONE  = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    logic [gap_pkg::DIM_W-1:0] cols_reg, rows_reg;
    logic [gap_pkg::EXT_W-1:0] cwid_reg, cdep_reg;

    logic [1:0]                  cmd_reg, cmd_next;
    logic [gap_pkg::POS_W-1:0]   sx_reg, sy_reg, ex_reg, ey_reg;
    logic [gap_pkg::PROBE_W-1:0] probe_reg;
    logic [NCW-1:0]              nc_reg, nc_next, nc_cfg;
    logic [NRW-1:0]              nr_reg, nr_next, nr_cfg;
    logic [UW-1:0]               used_reg, used_next;
    logic [CIW-1:0]              sc_reg, sc_next, ec_reg, ec_next;
    logic [RIW-1:0]              sr_reg, sr_next, er_reg, er_next;
    logic [1:0]                  dsel_reg, dsel_next;
    logic [IW-1:0]               sidx_reg, sidx_next, eidx_reg, eidx_next;
    logic [UW-1:0]               swp_reg, swp_next;
    logic                        clr_done_reg, clr_done_next;

    logic [UW-1:0]  scan_reg, scan_next;
    logic [CIW-1:0] scol_reg, scol_next;
    logic [RIW-1:0] srow_reg, srow_next;
    logic           pv_reg, pv_next;
    logic [IW-1:0]  pidx_reg, pidx_next;
    logic [CIW-1:0] pcol_reg, pcol_next;
    logic [RIW-1:0] prow_reg, prow_next;

    logic                        bf_reg, bf_next;
    logic [IW-1:0]               bidx_reg, bidx_next;
    logic [CIW-1:0]              bcol_reg, bcol_next;
    logic [RIW-1:0]              brow_reg, brow_next;
    logic [gap_pkg::COST_W-1:0]  best_est_reg, best_est_next;
    logic [gap_pkg::COST_W-1:0]  best_cost_reg, best_cost_next;
    logic [gap_pkg::COST_W-1:0]  g_reg, g_next;

    logic [1:0]     dir_reg, dir_next;
    logic [CIW-1:0] mc_reg, mc_next;
    logic [RIW-1:0] mr_reg, mr_next;
    logic [IW-1:0]  nidx_reg, nidx_next;
    logic [UW-1:0]  cnt_reg, cnt_next;
    logic           found_reg, found_next;
    logic           bit_reg, bit_next;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_found_reg, m_found_next;
    logic [gap_pkg::LEN_W-1:0]   m_len_reg, m_len_next;
    logic                        m_bit_reg, m_bit_next;

    gap_pkg::flag_t      a_rd, a_wd;
    gap_pkg::cell_word_t b_rd, b_wd;
    logic                a_we, b_we;
    logic [IW-1:0]       a_wa, b_wa, raddr;

    logic                        div_start, div_busy;
    logic [gap_pkg::POS_W-1:0]   div_num, div_q;
    logic [gap_pkg::EXT_W-1:0]   div_den, div_ext;
    logic                        sq_start, sq_busy;
    logic [RAD_W-1:0]            rad;
    logic [ROOT_W-1:0]           root;
    logic [gap_pkg::COST_W-1:0]  heur;
    logic [CIW-1:0]              hc, dc;
    logic [RIW-1:0]              hr, dr;
    logic                        skip;

    gap_ram #(.W($bits(gap_pkg::flag_t)), .DEPTH(NCELLS)) u_flag_ram (
        .aclk(aclk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(raddr), .rdata(a_rd)
    );

    gap_ram #(.W($bits(gap_pkg::cell_word_t)), .DEPTH(NCELLS)) u_cell_ram (
        .aclk(aclk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(raddr), .rdata(b_rd)
    );

    gap_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_num),
        .divisor(div_den), .busy(div_busy), .quotient(div_q)
    );

    gap_sqrt #(.RAD_W(RAD_W)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(rad),
        .busy(sq_busy), .root(root)
    );

    // clamp the grid size registers
    always_comb begin
        if (cols_reg == '0) begin
            nc_cfg = NCW'(1);
        end else if (int'(cols_reg) > MAX_COLS) begin
            nc_cfg = NCW'(MAX_COLS);
        end else begin
            nc_cfg = NCW'(cols_reg);
        end
        if (rows_reg == '0) begin
            nr_cfg = NRW'(1);
        end else if (int'(rows_reg) > MAX_ROWS) begin
            nr_cfg = NRW'(MAX_ROWS);
        end else begin
            nr_cfg = NRW'(rows_reg);
        end
    end

    // divider operand by conversion step: start x, start y, end x, end y
    always_comb begin
        unique case (dsel_reg)
            2'd0:    begin div_num = sx_reg; div_ext = cdep_reg; end
            2'd1:    begin div_num = sy_reg; div_ext = cwid_reg; end
            2'd2:    begin div_num = ex_reg; div_ext = cdep_reg; end
            default: begin div_num = ey_reg; div_ext = cwid_reg; end
        endcase
        div_den = (div_ext == '0) ? gap_pkg::EXT_W'(1) : div_ext;
    end

    assign hc   = (state_reg == S_SRD) ? sc_reg : mc_reg;
    assign hr   = (state_reg == S_SRD) ? sr_reg : mr_reg;
    assign dc   = (hc > ec_reg) ? hc - ec_reg : ec_reg - hc;
    assign dr   = (hr > er_reg) ? hr - er_reg : er_reg - hr;
    assign rad  = (RAD_W'(dc) * RAD_W'(dc) + RAD_W'(dr) * RAD_W'(dr)) << (2 * COST_FRAC_BITS);
    assign heur = gap_pkg::COST_W'(root);
    assign skip = (a_rd.closed || a_rd.open) && (b_rd.cost <= g_reg);

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        nc_next        = nc_reg;
        nr_next        = nr_reg;
        used_next      = used_reg;
        sc_next        = sc_reg;
        sr_next        = sr_reg;
        ec_next        = ec_reg;
        er_next        = er_reg;
        dsel_next      = dsel_reg;
        sidx_next      = sidx_reg;
        eidx_next      = eidx_reg;
        swp_next       = swp_reg;
        clr_done_next  = clr_done_reg;
        scan_next      = scan_reg;
        scol_next      = scol_reg;
        srow_next      = srow_reg;
        pv_next        = 1'b0;
        pidx_next      = pidx_reg;
        pcol_next      = pcol_reg;
        prow_next      = prow_reg;
        bf_next        = bf_reg;
        bidx_next      = bidx_reg;
        bcol_next      = bcol_reg;
        brow_next      = brow_reg;
        best_est_next  = best_est_reg;
        best_cost_next = best_cost_reg;
        g_next         = g_reg;
        dir_next       = dir_reg;
        mc_next        = mc_reg;
        mr_next        = mr_reg;
        nidx_next      = nidx_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        bit_next       = bit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_len_next     = m_len_reg;
        m_bit_next     = m_bit_reg;
        a_we           = 1'b0;
        a_wa           = bidx_reg;
        a_wd           = '0;
        b_we           = 1'b0;
        b_wa           = nidx_reg;
        b_wd           = b_rd;
        raddr          = nidx_reg;
        div_start      = 1'b0;
        sq_start       = 1'b0;

        unique case (state_reg)
            S_CCLR: begin
                b_we = 1'b1;
                b_wa = swp_reg[IW-1:0];
                b_wd = '0;
                if (swp_reg == UW'(NCELLS - 1)) begin
                    state_next    = clr_done_reg ? S_DONE : S_IDLE;
                    clr_done_next = 1'b0;
                end else begin
                    swp_next = swp_reg + 1'b1;
                end
            end
            S_IDLE: begin
                found_next = 1'b0;
                cnt_next   = '0;
                bit_next   = 1'b0;
                if (s_valid) begin
                    cmd_next = s_cmd;
                    nc_next  = nc_cfg;
                    nr_next  = nr_cfg;
                    priority case (s_cmd)
                        gap_pkg::CMD_FIND: begin
                            dsel_next  = 2'd0;
                            state_next = S_DIV;
                        end
                        gap_pkg::CMD_PROBE: state_next = S_PRD;
                        gap_pkg::CMD_CLEAR: begin
                            swp_next      = '0;
                            clr_done_next = 1'b1;
                            state_next    = S_CCLR;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (!div_busy) begin
                    unique case (dsel_reg)
                        2'd0: sc_next = (int'(div_q) > int'(nc_reg) - 1) ?
                                        CIW'(nc_reg - 1'b1) : CIW'(div_q);
                        2'd1: sr_next = (int'(div_q) > int'(nr_reg) - 1) ?
                                        RIW'(nr_reg - 1'b1) : RIW'(div_q);
                        2'd2: ec_next = (int'(div_q) > int'(nc_reg) - 1) ?
                                        CIW'(nc_reg - 1'b1) : CIW'(div_q);
                        default: er_next = (int'(div_q) > int'(nr_reg) - 1) ?
                                           RIW'(nr_reg - 1'b1) : RIW'(div_q);
                    endcase
                    if (dsel_reg == 2'd3) begin
                        state_next = S_IDX;
                    end else begin
                        dsel_next  = dsel_reg + 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_IDX: begin
                sidx_next  = IW'(sr_reg) * IW'(nc_reg) + IW'(sc_reg);
                eidx_next  = IW'(er_reg) * IW'(nc_reg) + IW'(ec_reg);
                used_next  = UW'(nc_reg) * UW'(nr_reg);
                swp_next   = '0;
                state_next = S_FCLR;
            end
            S_FCLR: begin
                // drop open and closed marks of the cells in use
                a_we = 1'b1;
                a_wa = swp_reg[IW-1:0];
                a_wd = '0;
                if (swp_reg == used_reg - 1'b1) begin
                    state_next = S_SRD;
                end else begin
                    swp_next = swp_reg + 1'b1;
                end
            end
            S_SRD: begin
                raddr      = sidx_reg;
                sq_start   = 1'b1;
                state_next = S_SWAIT;
            end
            S_SWAIT: begin
                raddr = sidx_reg;
                if (!sq_busy) begin
                    b_we = 1'b1;
                    b_wa = sidx_reg;
                    b_wd = '{corridor: b_rd.corridor, parent: b_rd.parent,
                             est: heur, cost: '0};
                    a_we = 1'b1;
                    a_wa = sidx_reg;
                    a_wd = '{open: 1'b1, closed: 1'b0};
                    scan_next  = '0;
                    scol_next  = '0;
                    srow_next  = '0;
                    bf_next    = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                raddr = scan_reg[IW-1:0];
                if (scan_reg < used_reg) begin
                    pv_next   = 1'b1;
                    pidx_next = scan_reg[IW-1:0];
                    pcol_next = scol_reg;
                    prow_next = srow_reg;
                    scan_next = scan_reg + 1'b1;
                    if (NCW'(scol_reg) == nc_reg - 1'b1) begin
                        scol_next = '0;
                        srow_next = srow_reg + 1'b1;
                    end else begin
                        scol_next = scol_reg + 1'b1;
                    end
                end else if (!pv_reg) begin
                    state_next = S_SEL;
                end
                // strict compare keeps the lowest index on ties
                if (pv_reg && a_rd.open && (!bf_reg || b_rd.est < best_est_reg)) begin
                    bf_next        = 1'b1;
                    bidx_next      = pidx_reg;
                    bcol_next      = pcol_reg;
                    brow_next      = prow_reg;
                    best_est_next  = b_rd.est;
                    best_cost_next = b_rd.cost;
                end
            end
            S_SEL: begin
                if (!bf_reg) begin
                    found_next = 1'b0;
                    state_next = S_DONE;
                end else if (bidx_reg == eidx_reg) begin
                    found_next = 1'b1;
                    mc_next    = ec_reg;
                    mr_next    = er_reg;
                    nidx_next  = eidx_reg;
                    cnt_next   = '0;
                    state_next = S_TCHK;
                end else begin
                    g_next     = gap_pkg::sat_add(best_cost_reg, STEP);
                    dir_next   = gap_pkg::DIR_PX;
                    state_next = S_NSET;
                end
            end
            S_NSET: begin
                mc_next = bcol_reg;
                mr_next = brow_reg;
                unique case (dir_reg)
                    gap_pkg::DIR_PX: begin
                        mc_next    = bcol_reg + 1'b1;
                        state_next = (NCW'(bcol_reg) + 1'b1 < nc_reg) ? S_NADDR : S_NSET;
                    end
                    gap_pkg::DIR_PY: begin
                        mr_next    = brow_reg + 1'b1;
                        state_next = (NRW'(brow_reg) + 1'b1 < nr_reg) ? S_NADDR : S_NSET;
                    end
                    gap_pkg::DIR_NX: begin
                        mc_next    = bcol_reg - 1'b1;
                        state_next = (bcol_reg != '0) ? S_NADDR : S_NSET;
                    end
                    default: begin
                        mr_next    = brow_reg - 1'b1;
                        state_next = (brow_reg != '0) ? S_NADDR : S_CLOSE;
                    end
                endcase
                if (state_next == S_NSET) begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            S_NADDR: begin
                nidx_next  = IW'(mr_reg) * IW'(nc_reg) + IW'(mc_reg);
                sq_start   = 1'b1;
                state_next = S_NRD;
            end
            S_NRD: begin
                state_next = S_NWAIT;
            end
            S_NWAIT: begin
                if (!sq_busy) begin
                    if (!skip) begin
                        a_we = 1'b1;
                        a_wa = nidx_reg;
                        a_wd = '{open: 1'b1, closed: 1'b0};
                        b_we = 1'b1;
                        b_wa = nidx_reg;
                        b_wd = '{corridor: b_rd.corridor, parent: dir_reg,
                                 est: gap_pkg::sat_add(g_reg, heur), cost: g_reg};
                    end
                    if (dir_reg == gap_pkg::DIR_NY) begin
                        state_next = S_CLOSE;
                    end else begin
                        dir_next   = dir_reg + 1'b1;
                        state_next = S_NSET;
                    end
                end
            end
            S_CLOSE: begin
                a_we       = 1'b1;
                a_wa       = bidx_reg;
                a_wd       = '{open: 1'b0, closed: 1'b1};
                scan_next  = '0;
                scol_next  = '0;
                srow_next  = '0;
                bf_next    = 1'b0;
                state_next = S_SCAN;
            end
            S_TCHK: begin
                state_next = (nidx_reg == sidx_reg || cnt_reg >= used_reg) ? S_DONE : S_TRD;
            end
            S_TRD: begin
                state_next = S_TWR;
            end
            S_TWR: begin
                b_we          = 1'b1;
                b_wa          = nidx_reg;
                b_wd          = b_rd;
                b_wd.corridor = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                // step back against the move that led into this cell
                unique case (b_rd.parent)
                    gap_pkg::DIR_PX: mc_next = (mc_reg != '0) ? mc_reg - 1'b1 : mc_reg;
                    gap_pkg::DIR_PY: mr_next = (mr_reg != '0) ? mr_reg - 1'b1 : mr_reg;
                    gap_pkg::DIR_NX: mc_next = (NCW'(mc_reg) + 1'b1 < nc_reg) ?
                                               mc_reg + 1'b1 : mc_reg;
                    default:         mr_next = (NRW'(mr_reg) + 1'b1 < nr_reg) ?
                                               mr_reg + 1'b1 : mr_reg;
                endcase
                state_next = S_TIDX;
            end
            S_TIDX: begin
                nidx_next  = IW'(mr_reg) * IW'(nc_reg) + IW'(mc_reg);
                state_next = S_TCHK;
            end
            S_PRD: begin
                raddr      = IW'(probe_reg);
                state_next = S_PWAIT;
            end
            S_PWAIT: begin
                raddr      = IW'(probe_reg);
                bit_next   = (int'(probe_reg) < NCELLS) && b_rd.corridor;
                state_next = S_DONE;
            end
            default: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_len_next   = (int'(cnt_reg) > int'(gap_pkg::LEN_MAX)) ?
                                   gap_pkg::LEN_MAX : gap_pkg::LEN_W'(cnt_reg);
                    m_bit_next   = bit_reg;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CCLR;
            swp_reg      <= '0;
            clr_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cols_reg     <= gap_pkg::DIM_W'(64);
            rows_reg     <= gap_pkg::DIM_W'(64);
            cwid_reg     <= gap_pkg::EXT_W'(100);
            cdep_reg     <= gap_pkg::EXT_W'(100);
        end else begin
            state_reg    <= state_next;
            swp_reg      <= swp_next;
            clr_done_reg <= clr_done_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    gap_pkg::REG_COLS:  cols_reg <= cfg_wr_data[gap_pkg::DIM_W-1:0];
                    gap_pkg::REG_ROWS:  rows_reg <= cfg_wr_data[gap_pkg::DIM_W-1:0];
                    gap_pkg::REG_WIDTH: cwid_reg <= cfg_wr_data;
                    default:            cdep_reg <= cfg_wr_data;
                endcase
            end
        end
        if (state_reg == S_IDLE && s_valid) begin
            sx_reg    <= s_start_x;
            sy_reg    <= s_start_y;
            ex_reg    <= s_end_x;
            ey_reg    <= s_end_y;
            probe_reg <= s_probe_cell;
        end
        cmd_reg       <= cmd_next;
        nc_reg        <= nc_next;
        nr_reg        <= nr_next;
        used_reg      <= used_next;
        sc_reg        <= sc_next;
        sr_reg        <= sr_next;
        ec_reg        <= ec_next;
        er_reg        <= er_next;
        dsel_reg      <= dsel_next;
        sidx_reg      <= sidx_next;
        eidx_reg      <= eidx_next;
        scan_reg      <= scan_next;
        scol_reg      <= scol_next;
        srow_reg      <= srow_next;
        pv_reg        <= pv_next;
        pidx_reg      <= pidx_next;
        pcol_reg      <= pcol_next;
        prow_reg      <= prow_next;
        bf_reg        <= bf_next;
        bidx_reg      <= bidx_next;
        bcol_reg      <= bcol_next;
        brow_reg      <= brow_next;
        best_est_reg  <= best_est_next;
        best_cost_reg <= best_cost_next;
        g_reg         <= g_next;
        dir_reg       <= dir_next;
        mc_reg        <= mc_next;
        mr_reg        <= mr_next;
        nidx_reg      <= nidx_next;
        cnt_reg       <= cnt_next;
        found_reg     <= found_next;
        bit_reg       <= bit_next;
        m_found_reg   <= m_found_next;
        m_len_reg     <= m_len_next;
        m_bit_reg     <= m_bit_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_path_found   = m_found_reg;
    assign m_path_length  = m_len_reg;
    assign m_corridor_bit = m_bit_reg;

    a_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        a_we |-> !(a_wd.open && a_wd.closed))
        else $error("flag write sets open and closed together");

    a_trace_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TCHK) |-> (cnt_reg <= used_reg))
        else $error("trace count past cells in use");

    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!sq_busy && !div_busy))
        else $error("arithmetic unit busy while taking a command");

    a_len_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_path_length != '0) |-> m_path_found)
        else $error("path length without a found path");

    a_bit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_corridor_bit) |-> !m_path_found)
        else $error("probe result and path result mixed");

endmodule
